@@ src/sspq_pkg.sv @@
// Shared types, codes and default sizes for the stable sorted priority queue.
package sspq_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PRIO_WIDTH_DEF = 8;

    // Operation codes on the mode field
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Status codes on the result
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_PUSH_CMP,
        S_REP_FRONT,
        S_REP_BACK,
        S_REP_OUT
    } t_state;

endpackage

@@ src/sspq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
module sspq_ram
    import sspq_pkg::*;
#(
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sspq_ctrl.sv @@
// Sequencer and datapath: sorted insert, pop by head advance, clear, front/back readout.
module sspq_ctrl
    import sspq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_mode,
    input  logic [DATA_WIDTH-1:0]              i_item_data,
    input  logic [PRIO_WIDTH-1:0]              i_item_priority,
    output logic                               o_result_valid,
    output logic [DATA_WIDTH-1:0]              o_popped_data,
    output logic [1:0]                         o_status,
    output logic [DATA_WIDTH-1:0]              o_front_data,
    output logic [DATA_WIDTH-1:0]              o_back_data,
    output logic [$clog2(DEPTH+1)-1:0]         o_entry_count,
    output logic                               o_queue_empty,
    // RAM port
    output logic                               o_ram_we,
    output logic [$clog2(DEPTH)-1:0]           o_ram_waddr,
    output logic [DATA_WIDTH+PRIO_WIDTH-1:0]   o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]           o_ram_raddr,
    input  logic [DATA_WIDTH+PRIO_WIDTH-1:0]   i_ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Logical slot index to physical RAM address (circular, head at slot 0)
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_k, n_k;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic [PRIO_WIDTH-1:0] r_prio, n_prio;
    logic [DATA_WIDTH-1:0] r_popped, n_popped;
    logic [1:0]            r_status, n_status;
    logic [DATA_WIDTH-1:0] r_front, n_front;

    logic                  r_o_valid, n_o_valid;
    logic [DATA_WIDTH-1:0] r_o_popped, n_o_popped;
    logic [1:0]            r_o_status, n_o_status;
    logic [DATA_WIDTH-1:0] r_o_front, n_o_front;
    logic [DATA_WIDTH-1:0] r_o_back, n_o_back;
    logic [CW-1:0]         r_o_count, n_o_count;
    logic                  r_o_empty, n_o_empty;

    logic                  w_accept;
    logic [CW-1:0]         w_count_m1;
    logic [AW-1:0]         w_last_idx;
    logic [AW-1:0]         w_k_m2;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [PRIO_WIDTH-1:0] w_rd_prio;
    logic                  w_shift;

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_count_m1 = r_count - CW'(1);
    assign w_last_idx = (r_count != '0) ? w_count_m1[AW-1:0] : '0;
    assign w_k_m2     = (r_k > AW'(1)) ? (r_k - AW'(2)) : '0;
    assign w_rd_data  = i_ram_rdata[DATA_WIDTH-1:0];
    assign w_rd_prio  = i_ram_rdata[DATA_WIDTH+PRIO_WIDTH-1:DATA_WIDTH];
    // held entry moves up one slot while its priority is strictly higher
    assign w_shift    = (r_k != '0) && (w_rd_prio > r_prio);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_mode)
                        MODE_PUSH: n_state = (r_count == DEPTH_C) ? S_REP_FRONT : S_PUSH_CMP;
                        MODE_POP:  n_state = (r_count == '0) ? S_REP_FRONT : S_POP_RD;
                        default:   n_state = S_REP_FRONT;
                    endcase
                end
            end
            S_POP_RD:    n_state = S_REP_FRONT;
            S_PUSH_CMP:  n_state = w_shift ? S_PUSH_CMP : S_REP_FRONT;
            S_REP_FRONT: n_state = S_REP_BACK;
            S_REP_BACK:  n_state = S_REP_OUT;
            S_REP_OUT:   n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_count     = r_count;
        n_head      = r_head;
        n_k         = r_k;
        n_data      = r_data;
        n_prio      = r_prio;
        n_popped    = r_popped;
        n_status    = r_status;
        n_front     = r_front;
        n_o_valid   = 1'b0;
        n_o_popped  = r_o_popped;
        n_o_status  = r_o_status;
        n_o_front   = r_o_front;
        n_o_back    = r_o_back;
        n_o_count   = r_o_count;
        n_o_empty   = r_o_empty;
        o_ram_we    = 1'b0;
        o_ram_waddr = f_phys(r_head, r_k);
        o_ram_wdata = {r_prio, r_data};
        o_ram_raddr = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_data   = i_item_data;
                    n_prio   = i_item_priority;
                    n_popped = '0;
                    n_status = ST_OK;
                    case (i_mode)
                        MODE_PUSH: begin
                            if (r_count == DEPTH_C) begin
                                n_status = ST_PUSH_FULL;
                            end else begin
                                // start the scan at the back
                                n_k         = r_count[AW-1:0];
                                o_ram_raddr = f_phys(r_head, w_last_idx);
                            end
                        end
                        MODE_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_POP_EMPTY;
                            end
                        end
                        MODE_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_POP_RD: begin
                n_popped = w_rd_data;
                n_head   = f_phys(r_head, AW'(1));
                n_count  = w_count_m1;
            end
            S_PUSH_CMP: begin
                o_ram_we = 1'b1;
                if (w_shift) begin
                    o_ram_wdata = i_ram_rdata;
                    n_k         = r_k - AW'(1);
                    o_ram_raddr = f_phys(r_head, w_k_m2);
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            S_REP_FRONT: o_ram_raddr = r_head;
            S_REP_BACK: begin
                n_front     = w_rd_data;
                o_ram_raddr = f_phys(r_head, w_last_idx);
            end
            S_REP_OUT: begin
                n_o_valid  = 1'b1;
                n_o_popped = r_popped;
                n_o_status = r_status;
                n_o_front  = (r_count == '0) ? '0 : r_front;
                n_o_back   = (r_count == '0) ? '0 : w_rd_data;
                n_o_count  = r_count;
                n_o_empty  = (r_count == '0);
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_head    <= n_head;
            r_o_valid <= n_o_valid;
        end
        r_k        <= n_k;
        r_data     <= n_data;
        r_prio     <= n_prio;
        r_popped   <= n_popped;
        r_status   <= n_status;
        r_front    <= n_front;
        r_o_popped <= n_o_popped;
        r_o_status <= n_o_status;
        r_o_front  <= n_o_front;
        r_o_back   <= n_o_back;
        r_o_count  <= n_o_count;
        r_o_empty  <= n_o_empty;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_o_valid;
    assign o_popped_data  = r_o_popped;
    assign o_status       = r_o_status;
    assign o_front_data   = r_o_front;
    assign o_back_data    = r_o_back;
    assign o_entry_count  = r_o_count;
    assign o_queue_empty  = r_o_empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("request accepted without going busy");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_PUSH_FULL) |-> (o_entry_count == DEPTH_C))
        else $error("push rejected while not full");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_POP_EMPTY) |-> (o_queue_empty && o_popped_data == '0))
        else $error("pop on empty reported with entries or data");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == S_PUSH_CMP))
        else $error("RAM written outside the insert scan");
`endif

endmodule

@@ src/stable_sorted_priority_queue_unit.sv @@
// A push scans from the back, moving each held entry of higher priority one slot back;
// a pop reads the head first; clear, no-op and rejected ops go straight to the readout.
// Throughput: one request at a time; busy stays high until the result strobe, and the
// next request is taken in the strobe cycle. The insert scan moves one entry per cycle
// through the single RAM read/write port pair. Reset (synchronous) empties the queue;
// RAM contents are not cleared. The receiver cannot stall the result.
module stable_sorted_priority_queue_unit
    import sspq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_mode,
    input  logic [DATA_WIDTH-1:0]      i_item_data,
    input  logic [PRIO_WIDTH-1:0]      i_item_priority,
    output logic                       o_result_valid,
    output logic [DATA_WIDTH-1:0]      o_popped_data,
    output logic [1:0]                 o_status,
    output logic [DATA_WIDTH-1:0]      o_front_data,
    output logic [DATA_WIDTH-1:0]      o_back_data,
    output logic [$clog2(DEPTH+1)-1:0] o_entry_count,
    output logic                       o_queue_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int MW = DATA_WIDTH + PRIO_WIDTH;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [MW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [MW-1:0] w_rdata;

    // Slot store: {priority, data} per entry
    sspq_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer
    sspq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .o_result_valid  (o_result_valid),
        .o_popped_data   (o_popped_data),
        .o_status        (o_status),
        .o_front_data    (o_front_data),
        .o_back_data     (o_back_data),
        .o_entry_count   (o_entry_count),
        .o_queue_empty   (o_queue_empty),
        .o_ram_we        (w_we),
        .o_ram_waddr     (w_waddr),
        .o_ram_wdata     (w_wdata),
        .o_ram_raddr     (w_raddr),
        .i_ram_rdata     (w_rdata)
    );

endmodule
